FILE: sv/lmja_pkg.sv
// ----------------------------------------------------------------------------
// lmja_pkg
// Shared types and codes of the node-side join/ack/query link controller.
// ----------------------------------------------------------------------------
package lmja_pkg;

    // event codes on cmd
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_SEND      = 3'd1;
    localparam logic [2:0] CMD_RX_FRAME  = 3'd2;
    localparam logic [2:0] CMD_RETRY_TMO = 3'd3;
    localparam logic [2:0] CMD_QUERY_TMO = 3'd4;

    // frame command codes, shared by rx_kind and tx_kind
    localparam logic [2:0] KIND_JOIN  = 3'd0;
    localparam logic [2:0] KIND_JRESP = 3'd1;
    localparam logic [2:0] KIND_DATA  = 3'd2;
    localparam logic [2:0] KIND_ACK   = 3'd3;
    localparam logic [2:0] KIND_QUERY = 3'd4;

    // timer actions
    localparam logic [1:0] TIMER_NONE  = 2'd0;
    localparam logic [1:0] TIMER_START = 2'd1;
    localparam logic [1:0] TIMER_STOP  = 2'd2;

    // mode as reported on mac_mode
    localparam logic [1:0] MAC_ALONE = 2'd0;
    localparam logic [1:0] MAC_READY = 2'd1;
    localparam logic [1:0] MAC_WAIT  = 2'd2;

    // register index, word address bit 2 on the APB port
    localparam logic REG_MAX_RETRIES = 1'b0;
    localparam logic REG_NODE_IDENT  = 1'b1;

    localparam logic [3:0] MAX_RETRIES_RESET = 4'd3;
    localparam logic [15:0] NODE_IDENT_RESET = 16'd0;

    typedef struct packed {
        logic [3:0]  max_retries;
        logic [15:0] node_ident;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        want_confirm;
        logic [2:0]  rx_kind;
        logic [7:0]  rx_seq;
        logic [15:0] rx_dest_prefix;
        logic [15:0] rx_dest_id;
        logic        rx_more;
        logic [7:0]  rx_len;
        logic [15:0] rx_new_prefix;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [2:0] tx_kind;
        logic [7:0] tx_seq;
        logic       tx_confirm;
        logic [1:0] retry_timer_op;
        logic [1:0] query_timer_op;
        logic       deliver_up;
        logic       joined;
        logic       join_backoff;
        logic       send_refused;
        logic [1:0] mac_mode;
        logic       last;
    } result_t;

endpackage

FILE: sv/lmja_regs.sv
// ----------------------------------------------------------------------------
// lmja_regs
// APB configuration registers: retry limit and node identifier.
// ----------------------------------------------------------------------------
module lmja_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lmja_pkg::cfg_t     cfg
);
    import lmja_pkg::*;

    logic        wr_en;
    logic [3:0]  max_retries_reg;
    logic [15:0] node_ident_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // word addressed, byte offset bits ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= MAX_RETRIES_RESET;
            node_ident_reg  <= NODE_IDENT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MAX_RETRIES: max_retries_reg <= pwdata[3:0];
                REG_NODE_IDENT:  node_ident_reg  <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_RETRIES: prdata = {28'd0, max_retries_reg};
            REG_NODE_IDENT:  prdata = {16'd0, node_ident_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.max_retries = max_retries_reg;
    assign cfg.node_ident  = node_ident_reg;

endmodule

FILE: sv/lmja_core.sv
// ----------------------------------------------------------------------------
// lmja_core
// Controller state and the single-pass event logic producing up to two results.
// ----------------------------------------------------------------------------
module lmja_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lmja_pkg::item_t         item,
    input  lmja_pkg::cfg_t          cfg,
    input  logic                    commit,
    output lmja_pkg::result_t [1:0] res,
    output logic [1:0]              res_cnt
);
    import lmja_pkg::*;

    typedef enum logic [2:0] {
        MODE_ALONE = 3'b001,
        MODE_READY = 3'b010,
        MODE_WAIT  = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  send_seq;
        logic [7:0]  expect_seq;
        logic [3:0]  retry_count;
        logic        query_pending;
        logic [2:0]  sent_kind;
        logic [7:0]  sent_seq;
        logic        sent_confirm;
        logic [15:0] own_prefix;
    } state_t;

    // working copy of state and results while one event is evaluated
    typedef struct packed {
        state_t           st;
        result_t [1:0]    res;
        logic             cur;
        logic             follow;
    } ctx_t;

    state_t state_reg;
    state_t state_next;
    ctx_t   ctx;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_ALONE: code = MAC_ALONE;
            MODE_READY: code = MAC_READY;
            MODE_WAIT:  code = MAC_WAIT;
            default:    code = MAC_ALONE;
        endcase
        return code;
    endfunction

    // a second transmit opens the second result
    function automatic ctx_t put_tx(input ctx_t c, input logic [2:0] k,
                                    input logic [7:0] s, input logic cf);
        ctx_t n;
        n = c;
        if (!n.cur && n.res[0].tx_valid)
        begin
            n.res[0].mac_mode = mode_code(n.st.mode);
            n.cur = 1'b1;
        end
        n.res[n.cur].tx_valid   = 1'b1;
        n.res[n.cur].tx_kind    = k;
        n.res[n.cur].tx_seq     = s;
        n.res[n.cur].tx_confirm = cf;
        return n;
    endfunction

    // follow is set when a held-back query has to go out instead
    function automatic ctx_t set_ready(input ctx_t c);
        ctx_t n;
        n = c;
        n.follow = 1'b0;
        if (n.st.mode == MODE_WAIT && n.st.query_pending)
        begin
            n.st.query_pending = 1'b0;
            n.follow = 1'b1;
        end
        else
        begin
            n.st.mode = MODE_READY;
        end
        return n;
    endfunction

    function automatic ctx_t emit_frame(input ctx_t c, input logic [2:0] k,
                                        input logic [7:0] s, input logic cf);
        ctx_t n;
        n = put_tx(c, k, s, cf);
        n.follow = 1'b0;
        if (k != KIND_JOIN)
            n.st.mode = MODE_WAIT;
        if (cf || k == KIND_QUERY || k == KIND_JOIN)
            n.res[n.cur].retry_timer_op = TIMER_START;
        else
            n = set_ready(n);
        return n;
    endfunction

    function automatic ctx_t new_frame(input ctx_t c, input logic [2:0] k,
                                       input logic cf);
        ctx_t n;
        logic [7:0] s;
        n = c;
        s = n.st.send_seq;
        n.st.send_seq     = s + 8'd1;
        n.st.sent_kind    = k;
        n.st.sent_seq     = s;
        n.st.sent_confirm = cf;
        return emit_frame(n, k, s, cf);
    endfunction

    function automatic ctx_t send_new(input ctx_t c, input logic [2:0] k,
                                      input logic cf);
        ctx_t n;
        n = new_frame(c, k, cf);
        if (n.follow)
            n = new_frame(n, KIND_QUERY, 1'b0);
        return n;
    endfunction

    function automatic ctx_t make_ready(input ctx_t c);
        ctx_t n;
        n = set_ready(c);
        if (n.follow)
            n = new_frame(n, KIND_QUERY, 1'b0);
        return n;
    endfunction

    function automatic ctx_t on_frame(input ctx_t c, input item_t it,
                                      input logic [15:0] ident);
        ctx_t n;
        logic to_me;
        n = c;
        to_me = (it.rx_dest_prefix == n.st.own_prefix) && (it.rx_dest_id == ident);
        if (it.rx_dest_prefix == n.st.own_prefix)
        begin
            case (it.rx_kind)
                KIND_JRESP:
                begin
                    if (n.st.mode == MODE_ALONE && to_me && it.rx_len == 8'd1 &&
                        it.rx_seq == 8'd0)
                    begin
                        n.res[n.cur].retry_timer_op = TIMER_STOP;
                        n.st.retry_count = 4'd0;
                        n.st.own_prefix  = it.rx_new_prefix;
                        n.res[n.cur].query_timer_op = TIMER_START;
                        n.st.expect_seq  = n.st.expect_seq + 8'd1;
                        n = make_ready(n);
                        n.res[n.cur].joined = 1'b1;
                    end
                end
                KIND_DATA:
                begin
                    if (n.st.mode != MODE_ALONE && it.rx_seq >= n.st.expect_seq)
                    begin
                        n.res[n.cur].retry_timer_op = TIMER_STOP;
                        n.res[n.cur].query_timer_op = TIMER_STOP;
                        n.st.retry_count = 4'd0;
                        n.st.expect_seq  = it.rx_seq + 8'd1;
                        n.res[n.cur].deliver_up = 1'b1;
                        if (it.rx_more)
                        begin
                            n = send_new(n, KIND_QUERY, 1'b0);
                        end
                        else
                        begin
                            n.res[n.cur].query_timer_op = TIMER_START;
                            n = make_ready(n);
                        end
                    end
                end
                KIND_ACK:
                begin
                    if (n.st.mode != MODE_ALONE && to_me && it.rx_seq == n.st.sent_seq)
                    begin
                        n.res[n.cur].retry_timer_op = TIMER_STOP;
                        n.st.retry_count = 4'd0;
                        if (n.st.sent_kind == KIND_QUERY)
                            n.res[n.cur].query_timer_op = TIMER_START;
                        n = make_ready(n);
                    end
                end
                default: ;
            endcase
        end
        return n;
    endfunction

    function automatic ctx_t on_retry(input ctx_t c, input logic [3:0] limit);
        ctx_t n;
        n = c;
        if (n.st.retry_count < limit)
        begin
            n.st.retry_count = n.st.retry_count + 4'd1;
            n = emit_frame(n, n.st.sent_kind, n.st.sent_seq, n.st.sent_confirm);
            if (n.follow)
                n = new_frame(n, KIND_QUERY, 1'b0);
        end
        else
        begin
            n.st.retry_count = 4'd0;
            if (n.st.sent_kind == KIND_JOIN)
            begin
                n.res[n.cur].join_backoff   = 1'b1;
                n.res[n.cur].retry_timer_op = TIMER_START;
            end
            else
            begin
                if (n.st.sent_kind == KIND_QUERY)
                    n.res[n.cur].query_timer_op = TIMER_START;
                n = make_ready(n);
            end
        end
        return n;
    endfunction

    always_comb
    begin
        ctx     = '0;
        ctx.st  = state_reg;
        case (item.cmd)
            CMD_START:
            begin
                ctx.st.mode       = MODE_ALONE;
                ctx.st.own_prefix = cfg.node_ident;
                ctx = send_new(ctx, KIND_JOIN, 1'b0);
            end
            CMD_SEND:
            begin
                if (ctx.st.mode == MODE_READY)
                    ctx = send_new(ctx, KIND_DATA, item.want_confirm);
                else
                    ctx.res[0].send_refused = 1'b1;
            end
            CMD_RX_FRAME:  ctx = on_frame(ctx, item, cfg.node_ident);
            CMD_RETRY_TMO: ctx = on_retry(ctx, cfg.max_retries);
            CMD_QUERY_TMO:
            begin
                if (ctx.st.mode == MODE_READY)
                    ctx = send_new(ctx, KIND_QUERY, 1'b0);
                else
                    ctx.st.query_pending = 1'b1;
            end
            default: ;
        endcase
        ctx.res[ctx.cur].mac_mode = mode_code(ctx.st.mode);
        ctx.res[ctx.cur].last     = 1'b1;
    end

    assign state_next = ctx.st;
    assign res        = ctx.res;
    assign res_cnt    = {1'b0, ctx.cur} + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_ALONE;
            state_reg.send_seq      <= 8'd0;
            state_reg.expect_seq    <= 8'd0;
            state_reg.retry_count   <= 4'd0;
            state_reg.query_pending <= 1'b0;
            state_reg.sent_kind     <= 3'd0;
            state_reg.sent_seq      <= 8'd0;
            state_reg.sent_confirm  <= 1'b0;
            state_reg.own_prefix    <= 16'd0;
        end
        else if (commit)
        begin
            state_reg <= state_next;
        end
    end

    // a second result only exists because a second frame goes out
    a_two_results_tx: assert property (@(posedge clk) disable iff (!rst_n)
        commit && res_cnt == 2'd2 |-> res[0].tx_valid && res[1].tx_valid)
        else $error("second result without two transmits");

    a_sent_seq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        commit && res[0].tx_valid && item.cmd != CMD_RETRY_TMO
        |=> state_reg.sent_seq == state_reg.send_seq - 8'd1)
        else $error("last sent sequence out of step with send counter");

endmodule

FILE: sv/lmja_outq.sv
// ----------------------------------------------------------------------------
// lmja_outq
// Two-entry result queue, takes one or two results per transfer-in cycle.
// ----------------------------------------------------------------------------
module lmja_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              push_n,
    input  lmja_pkg::result_t [1:0] push_res,
    output logic [1:0]              avail,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lmja_pkg::result_t       out_res
);
    import lmja_pkg::*;

    result_t [1:0] q_reg;
    result_t [1:0] q_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic [1:0]    base;
    logic          pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = q_reg[0];
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - {1'b0, pop};
    assign avail     = 2'd2 - base;

    always_comb
    begin
        q_next = q_reg;
        if (pop)
            q_next[0] = q_reg[1];
        if (push_n == 2'd2)
        begin
            q_next[0] = push_res[0];
            q_next[1] = push_res[1];
        end
        else if (push_n == 2'd1)
        begin
            q_next[base[0]] = push_res[0];
        end
        count_next = base + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |-> push_n <= avail)
        else $error("results pushed without room");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push_n == 2'd0 |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop on output transfer");

endmodule

FILE: sv/link_mac_join_ack_query_core.sv
// ----------------------------------------------------------------------------
// link_mac_join_ack_query_core
// Node-side link controller: join, data with acknowledgement, query polling.
// ----------------------------------------------------------------------------
// Each event is held in an input register and evaluated in one pass against
// the controller state; the one or two results it causes are written together
// into a two-entry result queue that drives the output channel, and the state
// is updated in the same cycle. An event that yields one result can be taken
// every cycle while out_ready is high; one that yields two holds the output
// for both its results, so the sustained rate is set by the result queue
// draining one result per cycle. in_ready depends combinationally on
// out_ready. There is no clearing pass after reset.
module link_mac_join_ack_query_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // event channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic        want_confirm,
    input  logic [2:0]  rx_kind,
    input  logic [7:0]  rx_seq,
    input  logic [15:0] rx_dest_prefix,
    input  logic [15:0] rx_dest_id,
    input  logic        rx_more,
    input  logic [7:0]  rx_len,
    input  logic [15:0] rx_new_prefix,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_valid,
    output logic [2:0]  tx_kind,
    output logic [7:0]  tx_seq,
    output logic        tx_confirm,
    output logic [1:0]  retry_timer_op,
    output logic [1:0]  query_timer_op,
    output logic        deliver_up,
    output logic        joined,
    output logic        join_backoff,
    output logic        send_refused,
    output logic [1:0]  mac_mode,
    output logic        last
);
    import lmja_pkg::*;

    cfg_t          cfg;
    item_t         item_reg;
    logic          in_valid_reg;
    logic          in_valid_next;
    logic          commit;
    result_t [1:0] res;
    logic [1:0]    res_cnt;
    logic [1:0]    avail;
    logic [1:0]    push_n;
    result_t       out_res;

    lmja_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // event leaves the input register once the queue can take all its results
    assign commit   = in_valid_reg && (res_cnt <= avail);
    assign in_ready = !in_valid_reg || commit;
    assign push_n   = commit ? res_cnt : 2'd0;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (commit)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd            <= cmd;
            item_reg.want_confirm   <= want_confirm;
            item_reg.rx_kind        <= rx_kind;
            item_reg.rx_seq         <= rx_seq;
            item_reg.rx_dest_prefix <= rx_dest_prefix;
            item_reg.rx_dest_id     <= rx_dest_id;
            item_reg.rx_more        <= rx_more;
            item_reg.rx_len         <= rx_len;
            item_reg.rx_new_prefix  <= rx_new_prefix;
        end
    end

    lmja_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_reg),
        .cfg     (cfg),
        .commit  (commit),
        .res     (res),
        .res_cnt (res_cnt)
    );

    lmja_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_res  (res),
        .avail     (avail),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign tx_valid       = out_res.tx_valid;
    assign tx_kind        = out_res.tx_kind;
    assign tx_seq         = out_res.tx_seq;
    assign tx_confirm     = out_res.tx_confirm;
    assign retry_timer_op = out_res.retry_timer_op;
    assign query_timer_op = out_res.query_timer_op;
    assign deliver_up     = out_res.deliver_up;
    assign joined         = out_res.joined;
    assign join_backoff   = out_res.join_backoff;
    assign send_refused   = out_res.send_refused;
    assign mac_mode       = out_res.mac_mode;
    assign last           = out_res.last;

endmodule

FILE: tb/link_mac_join_ack_query_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_mac_join_ack_query_core_test
// Drives join, send, frame and timer events into the link controller and
// checks every result against a cycle-free model of the node MAC. Runs a
// directed opening, then random phases under several register settings with
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module link_mac_join_ack_query_core_test;
    import lmja_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASE_ITEMS     = 125;

    // ------------------------------------------------------------------------
    // model of the node MAC: predicts the results of every accepted transfer
    // ------------------------------------------------------------------------
    class mac_reaction_scoreboard;
        logic [3:0]  retry_limit     = MAX_RETRIES_RESET;
        logic [15:0] node_id         = NODE_IDENT_RESET;
        logic [1:0]  mode            = MAC_ALONE;
        logic [7:0]  tx_seq_next     = '0;
        logic [7:0]  rx_seq_expected = '0;
        logic [3:0]  retries         = '0;
        bit          query_held      = 1'b0;
        logic [2:0]  last_kind       = KIND_JOIN;
        logic [7:0]  last_seq        = '0;
        logic        last_confirm    = 1'b0;
        logic [15:0] prefix          = '0;
        result_t     slot [2];
        int          slot_ix;
        result_t     awaited_results [$];
        int          errors = 0;

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_MAX_RETRIES)
                retry_limit = value[3:0];
            else if (idx == REG_NODE_IDENT)
                node_id = value[15:0];
        endfunction

        // a second frame in the same event opens the second result
        function void stage_tx(logic [2:0] k, logic [7:0] s, logic c);
            if (slot[slot_ix].tx_valid && slot_ix < 1)
            begin
                slot[slot_ix].mac_mode = mode;
                slot_ix++;
            end
            slot[slot_ix].tx_valid   = 1'b1;
            slot[slot_ix].tx_kind    = k;
            slot[slot_ix].tx_seq     = s;
            slot[slot_ix].tx_confirm = c;
        endfunction

        // returns 1 when a held-back query has to go out instead
        function bit try_ready();
            if (mode == MAC_WAIT && query_held)
            begin
                query_held = 1'b0;
                return 1'b1;
            end
            mode = MAC_READY;
            return 1'b0;
        endfunction

        function bit put_frame(logic [2:0] k, logic [7:0] s, logic c);
            stage_tx(k, s, c);
            if (k != KIND_JOIN)
                mode = MAC_WAIT;
            if (c || k == KIND_QUERY || k == KIND_JOIN)
            begin
                slot[slot_ix].retry_timer_op = TIMER_START;
                return 1'b0;
            end
            return try_ready();
        endfunction

        function bit fresh_frame(logic [2:0] k, logic c);
            logic [7:0] s;
            s = tx_seq_next;
            tx_seq_next++;
            last_kind    = k;
            last_seq     = s;
            last_confirm = c;
            return put_frame(k, s, c);
        endfunction

        function void send_fresh(logic [2:0] k, logic c);
            if (fresh_frame(k, c))
                void'(fresh_frame(KIND_QUERY, 1'b0));
        endfunction

        function void settle_ready();
            if (try_ready())
                void'(fresh_frame(KIND_QUERY, 1'b0));
        endfunction

        function void take_frame(item_t it);
            bit for_me;
            for_me = (it.rx_dest_prefix == prefix) && (it.rx_dest_id == node_id);
            if (it.rx_dest_prefix != prefix)
                return;
            case (it.rx_kind)
                KIND_JRESP:
                begin
                    if (mode == MAC_ALONE && for_me && it.rx_len == 8'd1 && it.rx_seq == 8'd0)
                    begin
                        slot[slot_ix].retry_timer_op = TIMER_STOP;
                        retries = '0;
                        prefix = it.rx_new_prefix;
                        slot[slot_ix].query_timer_op = TIMER_START;
                        rx_seq_expected++;
                        settle_ready();
                        slot[slot_ix].joined = 1'b1;
                    end
                end
                KIND_DATA:
                begin
                    if (mode == MAC_ALONE || it.rx_seq < rx_seq_expected)
                        return;
                    slot[slot_ix].retry_timer_op = TIMER_STOP;
                    slot[slot_ix].query_timer_op = TIMER_STOP;
                    retries = '0;
                    rx_seq_expected = it.rx_seq + 8'd1;
                    slot[slot_ix].deliver_up = 1'b1;
                    if (it.rx_more)
                        send_fresh(KIND_QUERY, 1'b0);
                    else
                    begin
                        slot[slot_ix].query_timer_op = TIMER_START;
                        settle_ready();
                    end
                end
                KIND_ACK:
                begin
                    if (mode == MAC_ALONE || !for_me || it.rx_seq != last_seq)
                        return;
                    slot[slot_ix].retry_timer_op = TIMER_STOP;
                    retries = '0;
                    if (last_kind == KIND_QUERY)
                        slot[slot_ix].query_timer_op = TIMER_START;
                    settle_ready();
                end
                default: ;
            endcase
        endfunction

        function void take_retry_timeout();
            if (retries < retry_limit)
            begin
                retries++;
                if (put_frame(last_kind, last_seq, last_confirm))
                    void'(fresh_frame(KIND_QUERY, 1'b0));
            end
            else
            begin
                retries = '0;
                if (last_kind == KIND_JOIN)
                begin
                    slot[slot_ix].join_backoff   = 1'b1;
                    slot[slot_ix].retry_timer_op = TIMER_START;
                end
                else
                begin
                    if (last_kind == KIND_QUERY)
                        slot[slot_ix].query_timer_op = TIMER_START;
                    settle_ready();
                end
            end
        endfunction

        function void note_event(item_t it);
            result_t r;
            slot[0] = '0;
            slot[1] = '0;
            slot_ix = 0;
            case (it.cmd)
                CMD_START:
                begin
                    mode = MAC_ALONE;
                    prefix = node_id;
                    send_fresh(KIND_JOIN, 1'b0);
                end
                CMD_SEND:
                begin
                    if (mode == MAC_READY)
                        send_fresh(KIND_DATA, it.want_confirm);
                    else
                        slot[slot_ix].send_refused = 1'b1;
                end
                CMD_RX_FRAME:  take_frame(it);
                CMD_RETRY_TMO: take_retry_timeout();
                CMD_QUERY_TMO:
                begin
                    if (mode == MAC_READY)
                        send_fresh(KIND_QUERY, 1'b0);
                    else
                        query_held = 1'b1;
                end
                default: ;
            endcase
            slot[slot_ix].mac_mode = mode;
            for (int k = 0; k <= slot_ix; k++)
            begin
                r = slot[k];
                r.last = (k == slot_ix);
                awaited_results.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_kind", want.tx_kind, got.tx_kind);
            compare_field("tx_seq", want.tx_seq, got.tx_seq);
            compare_field("tx_confirm", want.tx_confirm, got.tx_confirm);
            compare_field("retry_timer_op", want.retry_timer_op, got.retry_timer_op);
            compare_field("query_timer_op", want.query_timer_op, got.query_timer_op);
            compare_field("deliver_up", want.deliver_up, got.deliver_up);
            compare_field("joined", want.joined, got.joined);
            compare_field("join_backoff", want.join_backoff, got.join_backoff);
            compare_field("send_refused", want.send_refused, got.send_refused);
            compare_field("mac_mode", want.mac_mode, got.mac_mode);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd            = '0;
    logic        want_confirm   = 1'b0;
    logic [2:0]  rx_kind        = '0;
    logic [7:0]  rx_seq         = '0;
    logic [15:0] rx_dest_prefix = '0;
    logic [15:0] rx_dest_id     = '0;
    logic        rx_more        = 1'b0;
    logic [7:0]  rx_len         = '0;
    logic [15:0] rx_new_prefix  = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        tx_valid;
    logic [2:0]  tx_kind;
    logic [7:0]  tx_seq;
    logic        tx_confirm;
    logic [1:0]  retry_timer_op;
    logic [1:0]  query_timer_op;
    logic        deliver_up;
    logic        joined;
    logic        join_backoff;
    logic        send_refused;
    logic [1:0]  mac_mode;
    logic        last;

    mac_reaction_scoreboard sb = new;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_asks  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int cycles     = 0;

    int unsigned phase_retries [5] = '{0, 15, 5, 1, 3};
    int unsigned phase_ident   [5] = '{32'h0000, 32'hFFFF, 32'h00A5, 32'h5A3C, 32'h0000};
    int          phase_idle    [5] = '{0, 80, 0, 28, 0};
    int          phase_stall   [5] = '{0, 0, 80, 28, 0};

    link_mac_join_ack_query_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .want_confirm   (want_confirm),
        .rx_kind        (rx_kind),
        .rx_seq         (rx_seq),
        .rx_dest_prefix (rx_dest_prefix),
        .rx_dest_id     (rx_dest_id),
        .rx_more        (rx_more),
        .rx_len         (rx_len),
        .rx_new_prefix  (rx_new_prefix),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_valid       (tx_valid),
        .tx_kind        (tx_kind),
        .tx_seq         (tx_seq),
        .tx_confirm     (tx_confirm),
        .retry_timer_op (retry_timer_op),
        .query_timer_op (query_timer_op),
        .deliver_up     (deliver_up),
        .joined         (joined),
        .join_backoff   (join_backoff),
        .send_refused   (send_refused),
        .mac_mode       (mac_mode),
        .last           (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** link_mac_join_ack_query_core: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({tx_valid, tx_kind, tx_seq, tx_confirm, retry_timer_op,
                             query_timer_op, deliver_up, joined, join_backoff,
                             send_refused, mac_mode, last});
    end

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_readback(input logic idx, input logic [15:0] want);
        logic [15:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = (idx == REG_MAX_RETRIES) ? {12'd0, prdata[3:0]} : prdata[15:0];
        if (got !== want)
        begin
            $display("%0t: register %0d expected %0h, got %0h", $time, idx, want, got);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [3:0] retries, input logic [15:0] ident);
        apb_write(REG_MAX_RETRIES, {28'd0, retries});
        apb_write(REG_NODE_IDENT, {16'd0, ident});
        apb_readback(REG_MAX_RETRIES, {12'd0, retries});
        apb_readback(REG_NODE_IDENT, ident);
    endtask

    task automatic send_item(input item_t it);
        cmd            <= it.cmd;
        want_confirm   <= it.want_confirm;
        rx_kind        <= it.rx_kind;
        rx_seq         <= it.rx_seq;
        rx_dest_prefix <= it.rx_dest_prefix;
        rx_dest_id     <= it.rx_dest_id;
        rx_more        <= it.rx_more;
        rx_len         <= it.rx_len;
        rx_new_prefix  <= it.rx_new_prefix;
        in_valid       <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_event(it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.awaited_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic item_t event_item(logic [2:0] c, logic conf);
        item_t it;
        it = '0;
        it.cmd = c;
        it.want_confirm = conf;
        return it;
    endfunction

    function automatic item_t rx_item(logic [2:0] kind, logic [7:0] seq, logic [15:0] pre,
                                      logic [15:0] id, logic more, logic [7:0] len,
                                      logic [15:0] npre);
        item_t it;
        it = '0;
        it.cmd            = CMD_RX_FRAME;
        it.rx_kind        = kind;
        it.rx_seq         = seq;
        it.rx_dest_prefix = pre;
        it.rx_dest_id     = id;
        it.rx_more        = more;
        it.rx_len         = len;
        it.rx_new_prefix  = npre;
        return it;
    endfunction

    // mostly well-formed events aimed at the current state, some pure noise
    function automatic item_t build_item();
        item_t it;
        int    pick;
        int    sub;
        it.cmd            = 3'($urandom_range(7));
        it.want_confirm   = 1'($urandom_range(1));
        it.rx_kind        = 3'($urandom_range(7));
        it.rx_seq         = 8'($urandom_range(255));
        it.rx_dest_prefix = 16'($urandom_range(65535));
        it.rx_dest_id     = 16'($urandom_range(65535));
        it.rx_more        = 1'($urandom_range(1));
        it.rx_len         = 8'($urandom_range(255));
        it.rx_new_prefix  = 16'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 15)
            return it;
        if ($urandom_range(19) != 0)
            it.rx_dest_prefix = sb.prefix;
        if ($urandom_range(9) != 0)
            it.rx_dest_id = sb.node_id;
        if (pick < 23)
            it.cmd = CMD_START;
        else if (pick < 40)
            it.cmd = CMD_SEND;
        else if (pick < 50)
            it.cmd = CMD_QUERY_TMO;
        else if (pick < 63)
            it.cmd = CMD_RETRY_TMO;
        else
        begin
            it.cmd = CMD_RX_FRAME;
            sub = $urandom_range(9);
            if (sb.mode == MAC_ALONE ? sub < 8 : sub == 9)
            begin
                it.rx_kind = KIND_JRESP;
                if ($urandom_range(7) != 0)
                begin
                    it.rx_seq = 8'd0;
                    it.rx_len = 8'd1;
                end
            end
            else if (sub < 5)
            begin
                it.rx_kind = KIND_ACK;
                if ($urandom_range(7) != 0)
                    it.rx_seq = sb.last_seq;
            end
            else
            begin
                it.rx_kind = KIND_DATA;
                if ($urandom_range(5) != 0)
                    it.rx_seq = sb.rx_seq_expected + 8'($urandom_range(2));
            end
        end
        return it;
    endfunction

    initial
    begin
        item_t script [$];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_registers(4'd1, 16'h1234);
        script.push_back(event_item(CMD_SEND, 1'b1));          // refused while alone
        script.push_back(event_item(CMD_QUERY_TMO, 1'b0));     // query held back
        script.push_back(event_item(3'd5, 1'b0));              // unknown events
        script.push_back(event_item(3'd7, 1'b1));
        script.push_back(event_item(CMD_RETRY_TMO, 1'b0));     // nothing armed yet
        script.push_back(event_item(CMD_START, 1'b0));
        script.push_back(rx_item(KIND_DATA, 8'd5, 16'h1234, 16'h1234, 1'b0, 8'd3, 16'h0));
        script.push_back(rx_item(KIND_JRESP, 8'd0, 16'hFFFF, 16'h1234, 1'b0, 8'd1, 16'h0));
        script.push_back(rx_item(KIND_JRESP, 8'd0, 16'h1234, 16'h1234, 1'b0, 8'd2, 16'h0));
        script.push_back(rx_item(3'd6, 8'd0, 16'h1234, 16'h1234, 1'b1, 8'd1, 16'h0));
        script.push_back(rx_item(KIND_JOIN, 8'd0, 16'h1234, 16'h1234, 1'b0, 8'd1, 16'h0));
        script.push_back(rx_item(KIND_QUERY, 8'd0, 16'h1234, 16'h1234, 1'b0, 8'd1, 16'h0));
        script.push_back(event_item(CMD_RETRY_TMO, 1'b0));     // join retries run out
        script.push_back(rx_item(KIND_JRESP, 8'd0, 16'h1234, 16'h1234, 1'b0, 8'd1, 16'hFFFF));
        script.push_back(event_item(CMD_SEND, 1'b0));          // data then held query
        script.push_back(rx_item(KIND_ACK, 8'd2, 16'hFFFF, 16'h1234, 1'b0, 8'd0, 16'h0));
        script.push_back(event_item(CMD_QUERY_TMO, 1'b0));
        script.push_back(event_item(CMD_RETRY_TMO, 1'b0));
        script.push_back(rx_item(KIND_DATA, 8'd0, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 16'h0));
        script.push_back(rx_item(KIND_DATA, 8'd255, 16'hFFFF, 16'h0000, 1'b1, 8'd255,
                                 16'hFFFF));
        script.push_back(rx_item(KIND_DATA, 8'd0, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 16'h0));
        script.push_back(event_item(CMD_SEND, 1'b1));
        script.push_back(event_item(CMD_QUERY_TMO, 1'b0));
        script.push_back(rx_item(KIND_ACK, 8'd5, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 16'h0));
        script.push_back(event_item(CMD_RETRY_TMO, 1'b0));
        script.push_back(event_item(CMD_RETRY_TMO, 1'b0));     // gives up, sends held query
        script.push_back(rx_item(KIND_ACK, 8'd6, 16'hFFFF, 16'h1234, 1'b0, 8'd0, 16'h0));
        script.push_back(event_item(CMD_START, 1'b0));
        foreach (script[i])
            send_item(script[i]);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            idle_pct  = 0;
            stall_pct = 0;
            set_registers(4'(phase_retries[p]),
                          (p == 4) ? 16'($urandom_range(65535)) : 16'(phase_ident[p]));
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // the last phase stalls the receiver long enough to back up the input
                if (p == 4 && i == 20)
                    hold_asks++;
                send_item(build_item());
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("** link_mac_join_ack_query_core: PASSED **");
        else
            $display("** link_mac_join_ack_query_core: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
sv/lmja_pkg.sv
sv/lmja_regs.sv
sv/lmja_core.sv
sv/lmja_outq.sv
sv/link_mac_join_ack_query_core.sv
tb/link_mac_join_ack_query_core_test.sv
